/* rtl/ordered_list_with_delete_by_value_defines.svh */
// Assertion macros for the ordered list block and its port checker.
// No dependencies; include by bare file name.
`ifndef ORDERED_LIST_WITH_DELETE_BY_VALUE_DEFINES_SVH
`define ORDERED_LIST_WITH_DELETE_BY_VALUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OLDV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered list port check failed");

// Next-cycle implication, checked outside reset.
`define OLDV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered list port check failed");

`endif

/* rtl/oldv_pkg.sv */
// Command and status codes shared by the ordered list block and its checker.
// No dependencies.
package oldv_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE_VAL = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SRCH_R = 5'b00010,
    S_SRCH_C = 5'b00100,
    S_COPY_R = 5'b01000,
    S_COPY_W = 5'b10000
  } state_e;

endpackage

/* rtl/ordered_list_with_delete_by_value.sv */
// Ordered list of signed 32-bit values with insert/remove at both ends and remove by value.
// Depends on oldv_pkg (codes and state type).
//
// Usage:
//   A command beat (cmd_i, value_i) is taken at a rising edge with start_i high and
//   busy_o low. Every command yields exactly one result beat: status_o and count_o
//   are valid for the single cycle in which done_o is high, and the receiver must
//   take it then; it cannot hold results off.
// Storage is a circular buffer in a one-port-write, registered-read memory, with a
// head pointer and a count, so insert/remove at either end is a pointer update.
// Latency and throughput:
//   Insert front/back, remove front/back and unknown codes finish in the accept
//   cycle; done_o rises the next cycle and busy_o stays low, so one command per
//   cycle is sustained.
//   Remove by value on a non-empty list walks it through the single registered read
//   port and a shared 32-bit compare: a read and a compare state per element
//   searched, then a read and a write state per element moved to close the gap,
//   with busy_o high meanwhile; done_o rises in the cycle in which busy_o falls.
// Reset: the count, head and sequencer clear at once; memory contents are left as
//   they are and are only used below the count.
module ordered_list_with_delete_by_value #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [4:0]         count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // Logical position -> physical address, relative to the head.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (AW + 1)'(DEPTH)) s = s - (AW + 1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  oldv_pkg::state_e  state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic signed [31:0] val_q, val_d;
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic signed [31:0] mem_wd;

  logic              accept;
  logic              full;
  logic              empty;
  logic [CW-1:0]     cnt_m1;
  logic              at_last;
  logic              next_last;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     idx_inc;

  assign accept    = start_i && !busy_o;
  assign full      = (cnt_q == FULL_CNT);
  assign empty     = (cnt_q == '0);
  assign cnt_m1    = cnt_q - CW'(1);
  assign idx_inc   = idx_q + AW'(1);
  assign at_last   = (CW'(idx_q) == cnt_m1);
  assign next_last = (CW'(idx_q) + CW'(1) == cnt_m1);
  assign head_inc  = (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);
  assign head_dec  = (head_q == '0) ? LAST_ADDR : head_q - AW'(1);

  // Read the searched element, or the one behind the gap while compacting.
  assign rd_addr = phys(head_q, (state_q == oldv_pkg::S_COPY_R) ? idx_inc : idx_q);

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // Sequencer: end operations and unknown codes finish at accept; remove by value iterates unless the list is empty.
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    val_d    = val_q;
    done_d   = 1'b0;
    status_d = status_q;
    mem_we   = 1'b0;
    mem_wa   = phys(head_q, idx_q);
    mem_wd   = rdata_q;

    unique case (state_q)
      oldv_pkg::S_IDLE: begin
        if (accept) begin
          done_d   = 1'b1;
          status_d = oldv_pkg::ST_DONE;
          unique case (cmd_i)
            oldv_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                status_d = oldv_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = head_dec;
                mem_wd = value_i;
                head_d = head_dec;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            oldv_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                status_d = oldv_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = phys(head_q, cnt_q[AW-1:0]);
                mem_wd = value_i;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            oldv_pkg::CMD_POP_FRONT: begin
              if (empty) begin
                status_d = oldv_pkg::ST_EMPTY;
              end else begin
                head_d = head_inc;
                cnt_d  = cnt_m1;
              end
            end
            oldv_pkg::CMD_POP_BACK: begin
              if (empty) status_d = oldv_pkg::ST_EMPTY;
              else       cnt_d    = cnt_m1;
            end
            oldv_pkg::CMD_REMOVE_VAL: begin
              if (empty) begin
                status_d = oldv_pkg::ST_EMPTY;
              end else begin
                done_d  = 1'b0;
                idx_d   = '0;
                val_d   = value_i;
                state_d = oldv_pkg::S_SRCH_R;
              end
            end
            default: begin
              // Unknown codes: leave the list alone, report done.
            end
          endcase
        end
      end
      oldv_pkg::S_SRCH_R: begin
        state_d = oldv_pkg::S_SRCH_C;
      end
      oldv_pkg::S_SRCH_C: begin
        if (rdata_q == val_q) begin
          if (at_last) begin
            done_d   = 1'b1;
            status_d = oldv_pkg::ST_DONE;
            cnt_d    = cnt_m1;
            state_d  = oldv_pkg::S_IDLE;
          end else begin
            state_d = oldv_pkg::S_COPY_R;
          end
        end else if (at_last) begin
          done_d   = 1'b1;
          status_d = oldv_pkg::ST_NOT_FOUND;
          state_d  = oldv_pkg::S_IDLE;
        end else begin
          idx_d   = idx_inc;
          state_d = oldv_pkg::S_SRCH_R;
        end
      end
      oldv_pkg::S_COPY_R: begin
        state_d = oldv_pkg::S_COPY_W;
      end
      oldv_pkg::S_COPY_W: begin
        // Move the element behind the gap one place toward the front.
        mem_we = 1'b1;
        mem_wa = phys(head_q, idx_q);
        mem_wd = rdata_q;
        if (next_last) begin
          done_d   = 1'b1;
          status_d = oldv_pkg::ST_DONE;
          cnt_d    = cnt_m1;
          state_d  = oldv_pkg::S_IDLE;
        end else begin
          idx_d   = idx_inc;
          state_d = oldv_pkg::S_COPY_R;
        end
      end
      default: begin
        state_d = oldv_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oldv_pkg::S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    status_q <= status_d;
  end

  assign busy_o   = (state_q != oldv_pkg::S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign count_o  = 5'(cnt_q);

endmodule

/* rtl/oldv_checker.sv */
// Port-level checker for the ordered list block, bound to its top level.
// Depends on oldv_pkg and ordered_list_with_delete_by_value_defines.svh.
`include "ordered_list_with_delete_by_value_defines.svh"

module oldv_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [2:0]         cmd_i,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic [4:0]         count_o
);

  // Accepted command that finishes without a list walk.
  logic quick_cmd;
  assign quick_cmd = start_i && !busy_o && (cmd_i != oldv_pkg::CMD_REMOVE_VAL);

  `OLDV_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, done_o, !busy_o)

  `OLDV_ASSERT_NEXT(a_quick_cmd_done, clk_i, rst_ni, quick_cmd, done_o)

  `OLDV_ASSERT_NOW(a_full_count, clk_i, rst_ni, done_o && status_o == oldv_pkg::ST_FULL, count_o == 5'(DEPTH))

  `OLDV_ASSERT_NOW(a_empty_count, clk_i, rst_ni, done_o && status_o == oldv_pkg::ST_EMPTY, count_o == 5'd0)

  `OLDV_ASSERT_NOW(a_count_range, clk_i, rst_ni, DEPTH <= 31, count_o <= 5'(DEPTH))

endmodule

bind ordered_list_with_delete_by_value oldv_checker #(.DEPTH(DEPTH)) u_oldv_checker (.*);

/* verif/oldv_list_monitor.sv */
// Watches the command and reply channels of the ordered list, predicts each reply
// and compares it. Depends on oldv_pkg for command and status codes.
module oldv_list_monitor
  import oldv_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  logic               done_i,
  input  logic [1:0]         status_i,
  input  logic [4:0]         count_i,
  output int                 fail_count_o,
  output int                 outstanding_o,
  output int                 checked_o,
  output int                 full_seen_o,
  output int                 empty_seen_o,
  output int                 miss_seen_o
);

  typedef struct packed {
    status_e    status;
    logic [4:0] count;
  } list_reply_t;

  logic [31:0] list_vals [DEPTH];
  int          list_len;
  list_reply_t expected_replies [$];

  int fail_cnt;
  int checked_cnt;
  int full_cnt;
  int empty_cnt;
  int miss_cnt;

  assign fail_count_o = fail_cnt;
  assign checked_o    = checked_cnt;
  assign full_seen_o  = full_cnt;
  assign empty_seen_o = empty_cnt;
  assign miss_seen_o  = miss_cnt;

  initial begin
    fail_cnt    = 0;
    checked_cnt = 0;
    full_cnt    = 0;
    empty_cnt   = 0;
    miss_cnt    = 0;
    list_len    = 0;
  end

  // Drop the element at pos and pull later ones toward the front.
  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
    list_len--;
  endfunction

  function automatic list_reply_t apply_list_command(input logic [2:0] op,
                                                     input logic [31:0] val);
    list_reply_t r;
    int          pos;
    r.status = ST_DONE;
    pos      = -1;
    case (op)
      CMD_PUSH_FRONT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_vals[i] = list_vals[i - 1];
          list_vals[0] = val;
          list_len++;
        end
      end
      CMD_PUSH_BACK: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_vals[list_len] = val;
          list_len++;
        end
      end
      CMD_POP_FRONT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else close_gap(0);
      end
      CMD_POP_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      CMD_REMOVE_VAL: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (pos < 0 && list_vals[i] == val) pos = i;
          end
          if (pos < 0) r.status = ST_NOT_FOUND;
          else close_gap(pos);
        end
      end
      default: ;
    endcase
    r.count = 5'(list_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      list_len = 0;
      expected_replies.delete();
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_replies.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("reply with nothing pending: status %0d count %0d", status_i, count_i);
          end
          fail_cnt++;
        end else begin
          want = expected_replies.pop_front();
          checked_cnt++;
          if (status_i !== want.status || count_i !== want.count) begin
            if (fail_cnt < 10) begin
              $display("reply mismatch: status exp %0d got %0d, count exp %0d got %0d",
                       want.status, status_i, want.count, count_i);
            end
            fail_cnt++;
          end else begin
            case (want.status)
              ST_FULL:      full_cnt++;
              ST_EMPTY:     empty_cnt++;
              ST_NOT_FOUND: miss_cnt++;
              default: ;
            endcase
          end
        end
      end
      if (start_i && !busy_i) expected_replies.push_back(apply_list_command(cmd_i, value_i));
      outstanding_o <= expected_replies.size();
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the ordered list testbench: clock, reset, command stimulus and verdict.
// Depends on oldv_pkg, the ordered list block and oldv_list_monitor.
module testbench;
  import oldv_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int ITEM_TOTAL   = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  // Longest remove by value walks and compacts the whole list.
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  localparam logic [2:0] FIRST_UNUSED_CMD = 3'd5;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} burst_mode_e;

  logic               clk_i;
  logic               rst_ni  = 1'b0;
  logic               start_i = 1'b0;
  logic [2:0]         cmd_i   = '0;
  logic signed [31:0] value_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [1:0]         status_o;
  logic [4:0]         count_o;

  int fail_cnt;
  int outstanding;
  int checked_cnt;
  int full_cnt;
  int empty_cnt;
  int miss_cnt;
  int issued = 0;
  int cycle_cnt = 0;
  bit quiet_stretch = 1'b0;

  ordered_list_with_delete_by_value #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_i   (cmd_i),
    .value_i (value_i),
    .done_o  (done_o),
    .status_o(status_o),
    .count_o (count_o)
  );

  oldv_list_monitor #(
    .DEPTH(LIST_DEPTH)
  ) u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .count_i      (count_o),
    .fail_count_o (fail_cnt),
    .outstanding_o(outstanding),
    .checked_o    (checked_cnt),
    .full_seen_o  (full_cnt),
    .empty_seen_o (empty_cnt),
    .miss_seen_o  (miss_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops replies.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  // Present one command beat and hold it until the block takes it.
  task automatic issue_command(input logic [2:0] op, input logic [31:0] val);
    start_i <= 1'b1;
    cmd_i   <= op;
    value_i <= val;
    do @(posedge clk_i); while (busy_o);
    issued++;
  endtask

  // Drop start now and then, with junk on the payload so only start matters.
  task automatic maybe_idle();
    while (!quiet_stretch && $urandom_range(99) < 13) begin
      start_i <= 1'b0;
      cmd_i   <= 3'($urandom_range(7));
      value_i <= $urandom;
      @(posedge clk_i);
    end
  endtask

  // Hold off until every pending reply has come back.
  task automatic wait_all_replies();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Bias the mix so bursts sweep the list between empty and full.
  function automatic logic [2:0] pick_command(input burst_mode_e mode);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return FIRST_UNUSED_CMD + 3'($urandom_range(2));
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (roll < 45) return CMD_PUSH_FRONT;
        if (roll < 80) return CMD_PUSH_BACK;
        if (roll < 87) return CMD_POP_FRONT;
        if (roll < 93) return CMD_POP_BACK;
      end
      MODE_DRAIN: begin
        if (roll < 10) return CMD_PUSH_FRONT;
        if (roll < 20) return CMD_PUSH_BACK;
        if (roll < 45) return CMD_POP_FRONT;
        if (roll < 70) return CMD_POP_BACK;
      end
      default: begin
        if (roll < 20) return CMD_PUSH_FRONT;
        if (roll < 40) return CMD_PUSH_BACK;
        if (roll < 55) return CMD_POP_FRONT;
        if (roll < 70) return CMD_POP_BACK;
      end
    endcase
    return CMD_REMOVE_VAL;
  endfunction

  // Small values repeat often, so searches hit duplicates and misses alike.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5, 6: return 32'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    burst_mode_e mode;
    int          burst_len;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Removes of every kind on an empty list, then unused codes.
    issue_command(CMD_POP_FRONT, 32'h0);
    issue_command(CMD_POP_BACK, 32'h0);
    issue_command(CMD_REMOVE_VAL, 32'h0);
    issue_command(FIRST_UNUSED_CMD, 32'h1);
    issue_command(FIRST_UNUSED_CMD + 3'd1, 32'hffff_ffff);
    issue_command(FIRST_UNUSED_CMD + 3'd2, 32'h8000_0000);
    // Extremes at both ends, plus a duplicate to check first-match removal.
    issue_command(CMD_PUSH_FRONT, 32'h8000_0000);
    issue_command(CMD_PUSH_BACK, 32'h7fff_ffff);
    issue_command(CMD_PUSH_FRONT, 32'hffff_ffff);
    issue_command(CMD_PUSH_BACK, 32'h0000_0000);
    issue_command(CMD_PUSH_BACK, 32'hffff_ffff);
    issue_command(FIRST_UNUSED_CMD, 32'h0);
    issue_command(CMD_REMOVE_VAL, 32'h1234_5678);
    issue_command(CMD_REMOVE_VAL, 32'hffff_ffff);
    issue_command(CMD_REMOVE_VAL, 32'hffff_ffff);
    issue_command(CMD_REMOVE_VAL, 32'h7fff_ffff);
    issue_command(CMD_POP_FRONT, 32'h0);
    issue_command(CMD_POP_BACK, 32'h0);
    issue_command(CMD_REMOVE_VAL, 32'h0);
    wait_all_replies();

    // Random bursts; a quiet stretch in the middle runs back to back.
    while (issued < ITEM_TOTAL) begin
      mode      = burst_mode_e'($urandom_range(2));
      burst_len = $urandom_range(10, 60);
      repeat (burst_len) begin
        quiet_stretch = (issued >= 700 && issued < 1000);
        maybe_idle();
        issue_command(pick_command(mode), pick_value());
      end
      if ($urandom_range(3) == 0) wait_all_replies();
    end

    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d commands sent, %0d replies checked", issued, checked_cnt);
    $display("list full %0d times, empty %0d times, value missing %0d times",
             full_cnt, empty_cnt, miss_cnt);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* ordered_list_with_delete_by_value.f */
+incdir+rtl
rtl/oldv_pkg.sv
rtl/ordered_list_with_delete_by_value.sv
rtl/oldv_checker.sv
verif/oldv_list_monitor.sv
verif/testbench.sv
